// ===== hw/rtl/awd_pkg.sv =====
// shared types, codes and constants for the waveshaper distortion core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package awd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SINE_DEPTH_DEF  = 1024;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // taylor divisors, innermost term first
  localparam logic [6:0] SIN_DIVS [5] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};

  // reciprocals of the taylor divisors: floor(n / d) = (n * mag) >> sh for n < 2^30
  localparam logic [5:0]  RCP_SH  [5] = '{6'd37, 6'd37, 6'd36, 6'd35, 6'd33};
  localparam logic [30:0] RCP_MAG [5] = '{
    31'(((64'd1 << 37) + 64'd109) / 64'd110),
    31'(((64'd1 << 37) + 64'd71) / 64'd72),
    31'(((64'd1 << 36) + 64'd41) / 64'd42),
    31'(((64'd1 << 35) + 64'd19) / 64'd20),
    31'(((64'd1 << 33) + 64'd5) / 64'd6)
  };

  typedef enum logic [1:0] {
    MODE_HALF   = 2'd0,
    MODE_FULL   = 2'd1,
    MODE_SINE   = 2'd2,
    MODE_BYPASS = 2'd3
  } awd_mode_t;

  typedef enum logic [2:0] {
    CFG_MODE        = 3'd0,
    CFG_PRE_GAIN    = 3'd1,
    CFG_EFFECT_GAIN = 3'd2,
    CFG_CLIP_LEVEL  = 3'd3,
    CFG_CLIP_CENTER = 3'd4
  } awd_cfg_idx_t;

  typedef struct packed {
    awd_mode_t          mode;
    logic [15:0]        pre_gain;
    logic [15:0]        effect_gain;
    logic [14:0]        clip_level;
    logic signed [15:0] clip_center;
  } awd_cfg_t;

  typedef struct packed {
    logic [15:0] fx;
    logic [16:0] gain;
  } awd_coef_t;

  // sine of a q2.30 angle in [0, pi/2], q.30 result, truncating horner steps
  function automatic logic [63:0] sin_q30(input logic [63:0] theta);
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] d;
    t2 = (theta * theta) >> 30;
    p  = ONE_Q30;
    for (int k = 0; k < 5; k++) begin
      d = ((t2 * p) >> 30) / 64'(SIN_DIVS[k]);
      p = (d > ONE_Q30) ? 64'd0 : (ONE_Q30 - d);
    end
    return (theta * p) >> 30;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/audio_waveshaper_distortion_core.sv =====
// top level of the waveshaper distortion core: register file and wiring
// depends on awd_pkg, awd_coef_unit, awd_shaper_pipe (and awd_sine_rom)
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input beat: drive in_sample_in and raise start; a beat is taken at a
//   clock edge where start is high and busy is low
// - result beat: out_sample_out is valid for exactly one cycle while
//   out_valid is high; there is no back-pressure on the result side
// - throughput: one sample per clock whenever busy is low
// - pipeline: the result passes the registered stages in order from the
//   accepting edge (pre-gain products, square and table index, mix, output
//   gain, window clip and saturation)
// - configuration: cfg_we with cfg_index/cfg_data writes one register per
//   cycle; each write restarts the coefficient unit, which recomputes the
//   effective mix gain and 1/(1+mix gain) with a shared bit-serial divider
// - busy is high while that recompute runs; in sinusoid mode with pre-gain
//   below one half it first takes the taylor sine of the clip level by
//   reciprocal multiplies, then divides by it (no divide if it is zero)
// - reset: registers return to their defaults, the pipeline empties and a
//   recompute runs, so busy is high after reset until that recompute ends
// - mode three passes the sample straight through

module audio_waveshaper_distortion_core #(
  parameter int SAMPLE_BITS      = awd_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = awd_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                              out_valid,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_out,
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [15:0]                  cfg_data
);
  import awd_pkg::*;

  awd_cfg_t  cfg_r;
  awd_coef_t coef;
  logic      coef_busy;
  logic      in_take;

  // register file; the user must write it only while no beat is in flight, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= MODE_HALF;
      cfg_r.pre_gain    <= 16'd2560;
      cfg_r.effect_gain <= 16'd256;
      cfg_r.clip_level  <= 15'd26214;
      cfg_r.clip_center <= 16'sd0;
    end else if (cfg_we) begin
      case (awd_cfg_idx_t'(cfg_index))
        CFG_MODE:        cfg_r.mode        <= awd_mode_t'(cfg_data[1:0]);
        CFG_PRE_GAIN:    cfg_r.pre_gain    <= cfg_data;
        CFG_EFFECT_GAIN: cfg_r.effect_gain <= cfg_data;
        CFG_CLIP_LEVEL:  cfg_r.clip_level  <= cfg_data[14:0];
        CFG_CLIP_CENTER: cfg_r.clip_center <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // gain coefficients follow every write
  awd_coef_unit u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .cfg     (cfg_r),
    .coef    (coef),
    .busy    (coef_busy)
  );

  assign busy    = coef_busy;
  assign in_take = start && !coef_busy;

  // per-sample datapath, one beat per clock while busy is low
  awd_shaper_pipe #(
    .SB    (SAMPLE_BITS),
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .coef      (coef),
    .in_valid  (in_take),
    .in_x      (in_sample_in),
    .out_valid (out_valid),
    .out_y     (out_sample_out)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/awd_sine_rom.sv =====
// full-wave sine table with registered read, built at elaboration
// depends on awd_pkg (sin_q30, constants)
`timescale 1ns / 1ps
`default_nettype none

module awd_sine_rom #(
  parameter int SB    = awd_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH = awd_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic signed [SB:0]              rd_data_r
);
  import awd_pkg::*;

  localparam int FRAC = SB - 1;
  localparam int UPSH = (FRAC >= 30) ? FRAC - 30 : 0;
  localparam int DNSH = (FRAC < 30) ? 30 - FRAC : 0;
  localparam logic [63:0] RND = (64'd1 << DNSH) >> 1;

  function automatic logic signed [63:0] sine_entry(input int unsigned idx);
    logic [63:0] q4;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] th;
    logic [63:0] s;
    logic [63:0] v;
    q4   = 64'(idx) * 64'd4;
    quad = q4 / DEPTH;
    rem  = q4 % DEPTH;
    if (quad[0]) begin
      rem = 64'(DEPTH) - rem;
    end
    th = (rem * HALF_PI_Q30) / DEPTH;
    s  = sin_q30(th);
    if (FRAC >= 30) begin
      v = s << UPSH;
    end else begin
      v = (s + RND) >> DNSH;
    end
    return (quad >= 64'd2) ? -$signed(v) : $signed(v);
  endfunction

  // one bit above the sample width: the positive peak rounds up to full scale
  logic signed [SB:0] rom_w [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_rom
    assign rom_w[g] = (SB+1)'(sine_entry(g));
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rom_w[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/awd_coef_unit.sv =====
// derives effective mix gain and output gain after each register write
// depends on awd_pkg; shared multiplier and bit-serial divider
`timescale 1ns / 1ps
`default_nettype none

module awd_coef_unit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              restart,
  input  wire awd_pkg::awd_cfg_t cfg,
  output awd_pkg::awd_coef_t     coef,
  output logic                   busy
);
  import awd_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_LAUNCH = 9'b000000010,
    ST_TSQ    = 9'b000000100,
    ST_PMUL   = 9'b000001000,
    ST_PDIV   = 9'b000010000,
    ST_SMUL   = 9'b000100000,
    ST_FDIV   = 9'b001000000,
    ST_GSET   = 9'b010000000,
    ST_GDIV   = 9'b100000000
  } coef_state_t;

  coef_state_t state_r;
  logic [29:0] th_r;
  logic [29:0] t2_r;
  logic [30:0] p_r;
  logic [29:0] pd_x_r;
  logic [2:0]  k_r;
  logic [15:0] fx_r;
  logic [16:0] gain_r;

  logic [47:0] div_num_r;
  logic [47:0] div_quo_r;
  logic [31:0] div_den_r;
  logic [31:0] div_rem_r;
  logic [5:0]  div_cnt_r;
  logic        div_run_r;

  logic [30:0] mul_a;
  logic [30:0] mul_b;
  logic [61:0] mul_p;
  logic [31:0] mul_q;
  logic [61:0] rcp_q;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        rem_ge;
  logic [16:0] den_g;
  logic        corr;

  always_comb begin
    case (state_r)
      ST_TSQ: begin
        mul_a = {1'b0, th_r};
        mul_b = {1'b0, th_r};
      end
      ST_PMUL: begin
        mul_a = {1'b0, t2_r};
        mul_b = p_r;
      end
      ST_PDIV: begin
        // taylor divide by constant as a reciprocal multiply
        mul_a = {1'b0, pd_x_r};
        mul_b = RCP_MAG[k_r];
      end
      default: begin
        mul_a = {1'b0, th_r};
        mul_b = p_r;
      end
    endcase
    mul_p   = 62'(mul_a) * 62'(mul_b);
    mul_q   = mul_p[61:30];
    rcp_q   = mul_p >> RCP_SH[k_r];
    rem_sh  = {div_rem_r, div_num_r[47]};
    rem_sub = rem_sh - {1'b0, div_den_r};
    rem_ge  = rem_sh >= {1'b0, div_den_r};
    den_g   = 17'd256 + 17'(fx_r);
    corr    = (cfg.mode == MODE_SINE) && (cfg.pre_gain < 16'd128);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LAUNCH;
      div_run_r <= 1'b0;
    end else begin
      // restoring divider, one quotient bit per cycle
      if (div_run_r) begin
        div_num_r <= {div_num_r[46:0], 1'b0};
        div_rem_r <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
        div_quo_r <= {div_quo_r[46:0], rem_ge};
        div_cnt_r <= div_cnt_r - 6'd1;
        if (div_cnt_r == 6'd1) begin
          div_run_r <= 1'b0;
        end
      end
      if (restart) begin
        state_r <= ST_LAUNCH;
      end else begin
        case (state_r)
          ST_IDLE: begin
          end
          ST_LAUNCH: begin
            if (corr) begin
              th_r    <= {cfg.clip_level, 15'd0};
              state_r <= ST_TSQ;
            end else begin
              fx_r    <= cfg.effect_gain;
              state_r <= ST_GSET;
            end
          end
          ST_TSQ: begin
            t2_r    <= mul_q[29:0];
            p_r     <= 31'(ONE_Q30);
            k_r     <= 3'd0;
            state_r <= ST_PMUL;
          end
          ST_PMUL: begin
            pd_x_r  <= mul_q[29:0];
            state_r <= ST_PDIV;
          end
          ST_PDIV: begin
            p_r     <= (rcp_q > 62'(ONE_Q30)) ? 31'd0 : 31'(62'(ONE_Q30) - rcp_q);
            k_r     <= k_r + 3'd1;
            state_r <= (k_r == 3'd4) ? ST_SMUL : ST_PMUL;
          end
          ST_SMUL: begin
            if (mul_q == 32'd0) begin
              // zero sine of clip: divisor saturates the mix gain
              fx_r    <= 16'hFFFF;
              state_r <= ST_GSET;
            end else begin
              div_num_r <= {2'b00, cfg.effect_gain, 30'd0};
              div_den_r <= mul_q;
              div_rem_r <= '0;
              div_quo_r <= '0;
              div_cnt_r <= 6'd48;
              div_run_r <= 1'b1;
              state_r   <= ST_FDIV;
            end
          end
          ST_FDIV: begin
            if (!div_run_r) begin
              fx_r    <= (div_quo_r > 48'd65535) ? 16'hFFFF : div_quo_r[15:0];
              state_r <= ST_GSET;
            end
          end
          ST_GSET: begin
            div_num_r <= 48'(25'h100_0000 + 25'(den_g >> 1));
            div_den_r <= 32'(den_g);
            div_rem_r <= '0;
            div_quo_r <= '0;
            div_cnt_r <= 6'd48;
            div_run_r <= 1'b1;
            state_r   <= ST_GDIV;
          end
          ST_GDIV: begin
            if (!div_run_r) begin
              gain_r  <= div_quo_r[16:0];
              state_r <= ST_IDLE;
            end
          end
          default: begin
            state_r <= ST_LAUNCH;
          end
        endcase
      end
    end
  end

  assign coef = {fx_r, gain_r};
  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/awd_shaper_pipe.sv =====
// five-stage shaping datapath: products, square/index, mix, gain, clip
// depends on awd_pkg and awd_sine_rom
`timescale 1ns / 1ps
`default_nettype none

module awd_shaper_pipe #(
  parameter int SB    = awd_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH = awd_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire awd_pkg::awd_cfg_t   cfg,
  input  wire awd_pkg::awd_coef_t  coef,
  input  wire logic                in_valid,
  input  wire logic signed [SB-1:0] in_x,
  output logic                     out_valid,
  output logic signed [SB-1:0]     out_y
);
  import awd_pkg::*;

  localparam int F  = SB - 1;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = SB + 2;
  localparam int MW = SB + 16;
  localparam int UW = F + 9;
  localparam int IW = UW + AW + 1;
  localparam int TW = SB + 20;
  localparam int GW = TW + 18;
  localparam int YW = GW - 24;
  localparam logic signed [YW-1:0] SMAX = YW'({1'b0, {F{1'b1}}});
  localparam logic signed [YW-1:0] SMIN = ~SMAX;
  localparam logic signed [GW-1:0] RND  = GW'(24'h80_0000);

  // clip window in sample format
  logic signed [CW-1:0] asym;
  logic signed [CW-1:0] clip;
  logic signed [CW-1:0] pos;
  logic signed [CW-1:0] neg;

  if (F >= 15) begin : g_up
    assign asym = CW'(cfg.clip_center) <<< (F - 15);
    assign clip = CW'($signed({1'b0, cfg.clip_level})) <<< (F - 15);
  end else begin : g_dn
    localparam int DS = 15 - F;
    logic signed [17:0] cc_ext;
    logic signed [17:0] cl_ext;
    assign cc_ext = 18'(cfg.clip_center) + 18'(1 << (DS - 1));
    assign cl_ext = $signed({3'b000, cfg.clip_level}) + 18'(1 << (DS - 1));
    assign asym   = CW'(cc_ext >>> DS);
    assign clip   = CW'(cl_ext >>> DS);
  end

  assign pos = asym + clip;
  assign neg = asym - clip;

  // stage 1: pre-gain and square products
  logic [SB-1:0]   ax;
  logic [MW-1:0]   prod_pg;
  logic [MW-1:0]   prod_neg;
  logic [2*SB-1:0] prod_sq;

  logic                 s1_v_r;
  logic signed [SB-1:0] s1_x_r;
  logic [SB+7:0]        s1_m_r;
  logic [SB:0]          s1_sq_r;
  logic [UW-1:0]        s1_u_r;

  always_comb begin
    ax       = in_x[SB-1] ? (~in_x + 1'b1) : in_x;
    prod_pg  = MW'(ax) * MW'(cfg.pre_gain);
    prod_neg = ~prod_pg + 1'b1;
    prod_sq  = (2*SB)'(ax) * (2*SB)'(ax);
  end

  always_ff @(posedge clk) begin
    s1_x_r  <= in_x;
    s1_m_r  <= prod_pg[MW-1:8];
    s1_sq_r <= prod_sq[2*SB-1:F];
    s1_u_r  <= in_x[SB-1] ? prod_neg[UW-1:0] : prod_pg[UW-1:0];
  end

  // stage 2: limited square, scaled square, table index
  logic [SB-1:0]   m_lim;
  logic [2*SB-1:0] sq0_full;
  logic [SB+16:0]  w1_full;
  logic [IW-1:0]   idx_full;
  logic [AW-1:0]   idx;

  logic                 s2_v_r;
  logic signed [SB-1:0] s2_x_r;
  logic [SB:0]          s2_sq0_r;
  logic [SB+8:0]        s2_w1_r;
  logic signed [SB:0]   rom_q;

  always_comb begin
    m_lim    = (s1_m_r[SB+7:SB] != 8'd0) ? {SB{1'b1}} : s1_m_r[SB-1:0];
    sq0_full = (2*SB)'(m_lim) * (2*SB)'(m_lim);
    w1_full  = (SB+17)'(s1_sq_r) * (SB+17)'(cfg.pre_gain);
    idx_full = IW'(s1_u_r) * IW'(DEPTH);
    idx      = idx_full[UW+AW-1:UW];
  end

  awd_sine_rom #(
    .SB    (SB),
    .DEPTH (DEPTH)
  ) u_rom (
    .clk       (clk),
    .rd_addr   (idx),
    .rd_data_r (rom_q)
  );

  always_ff @(posedge clk) begin
    s2_x_r   <= s1_x_r;
    s2_sq0_r <= sq0_full[2*SB-1:F];
    s2_w1_r  <= w1_full[SB+16:8];
  end

  // stage 3: pick shaped term, mix with input
  logic signed [CW-1:0] sq0_s;
  logic signed [CW-1:0] w0_pre;
  logic signed [CW-1:0] w0;
  logic signed [CW-1:0] w1;
  logic signed [CW-1:0] w;
  logic signed [TW-1:0] t;

  logic                 s3_v_r;
  logic signed [SB-1:0] s3_x_r;
  logic signed [TW-1:0] s3_t_r;

  always_comb begin
    sq0_s  = $signed({1'b0, s2_sq0_r});
    w0_pre = s2_x_r[SB-1] ? -sq0_s : sq0_s;
    if (w0_pre > pos) begin
      w0 = pos;
    end else if (w0_pre < neg) begin
      w0 = neg;
    end else begin
      w0 = w0_pre;
    end
    w1 = (s2_w1_r > (SB+9)'($unsigned(clip))) ? clip : CW'(s2_w1_r);
    case (cfg.mode)
      MODE_HALF: w = w0;
      MODE_FULL: w = w1;
      MODE_SINE: w = CW'(rom_q);
      default:   w = '0;
    endcase
    t = (TW'(s2_x_r) <<< 8) + TW'(w) * TW'($signed({1'b0, coef.fx}));
  end

  always_ff @(posedge clk) begin
    s3_x_r <= s2_x_r;
    s3_t_r <= t;
  end

  // stage 4: output gain
  logic                 s4_v_r;
  logic signed [SB-1:0] s4_x_r;
  logic signed [GW-1:0] s4_tg_r;

  always_ff @(posedge clk) begin
    s4_x_r  <= s3_x_r;
    s4_tg_r <= GW'(s3_t_r) * GW'($signed({1'b0, coef.gain}));
  end

  // stage 5: round, window clip in sinusoid mode, saturate
  logic signed [GW-1:0] tg_rnd;
  logic signed [YW-1:0] y_g;
  logic signed [YW-1:0] y_c;
  logic signed [YW-1:0] pos_y;
  logic signed [YW-1:0] neg_y;

  logic                 out_valid_r;
  logic signed [SB-1:0] out_y_r;

  always_comb begin
    tg_rnd = s4_tg_r + RND;
    y_g    = YW'(tg_rnd >>> 24);
    pos_y  = YW'(pos);
    neg_y  = YW'(neg);
    case (cfg.mode)
      MODE_SINE: begin
        if (y_g > pos_y) begin
          y_c = pos_y;
        end else if (y_g < neg_y) begin
          y_c = neg_y;
        end else begin
          y_c = y_g;
        end
      end
      MODE_BYPASS: y_c = YW'(s4_x_r);
      default:     y_c = y_g;
    endcase
  end

  always_ff @(posedge clk) begin
    if (y_c > SMAX) begin
      out_y_r <= SB'(SMAX);
    end else if (y_c < SMIN) begin
      out_y_r <= SB'(SMIN);
    end else begin
      out_y_r <= SB'(y_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= s4_v_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_y     = out_y_r;

endmodule

`default_nettype wire
